// ===== sv/mtrob_pkg.sv =====
package mtrob_pkg;

  localparam int THREADS        = 4;
  localparam int MAX_PER_THREAD = 64;
  localparam int TAG_BITS       = 16;
  localparam int DEPTH          = THREADS * MAX_PER_THREAD;
  localparam int PTR_W          = $clog2(DEPTH);
  localparam int CNT_W          = $clog2(DEPTH + 1);
  localparam int THR_W          = 2;
  localparam int E_W            = 7;
  localparam int FUNC_W         = 3;
  localparam int REL_W          = 8;
  localparam int STAT_W         = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 7;
  localparam int PORT_TAG_W     = 16;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_STATUS    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ENQ       = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REM_OLD   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REM_YOUNG = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ      = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] RS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] RS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] RS_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] RS_RANGE = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE = 1'd1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PRIV_OP,
    CMD_CAP_R,
    CMD_RD_HEAD,
    CMD_CAP_H,
    CMD_RD_TAIL,
    CMD_CAP_T,
    CMD_TRIM_H,
    CMD_TRIM_T,
    CMD_SH_OP,
    CMD_SCAN_HEAD,
    CMD_SCAN_TAIL,
    CMD_SCAN_ISSUE,
    CMD_SCAN_CHECK,
    CMD_RD_SHEAD
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic cap_deq;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic mode_shared;
    logic priv_read_ok;
    logic op_scan;
    logic trim_h_more;
    logic trim_t_more;
    logic scan_end;
    logic scan_hit;
    logic tcnt_nz;
  } dp_stat_t;

  // Clamp the size register to 1..MAX_PER_THREAD
  function automatic logic [E_W-1:0] eff_size(input logic [E_W-1:0] val);
    logic [E_W-1:0] res;
    res = val;
    if (val == '0) res = E_W'(1);
    if (val > E_W'(MAX_PER_THREAD)) res = E_W'(MAX_PER_THREAD);
    return res;
  endfunction

endpackage

// ===== sv/mtrob_dp.sv =====
module mtrob_dp import mtrob_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [THR_W-1:0]      thread_id_i,
  input  logic [PORT_TAG_W-1:0] entry_tag_i,
  input  logic [REL_W-1:0]      rel_index_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  output logic [STAT_W-1:0]     status_o,
  output logic [PORT_TAG_W-1:0] read_tag_o,
  output logic                  read_valid_o,
  output logic [PORT_TAG_W-1:0] head_tag_o,
  output logic                  head_valid_o,
  output logic [PORT_TAG_W-1:0] tail_tag_o,
  output logic                  tail_valid_o,
  output logic [CNT_W-1:0]      thread_count_o,
  output logic                  can_enqueue_o,
  output logic                  can_dequeue_o
);

  typedef enum logic [1:0] {PU_REMOVE, PU_READ, PU_HEAD, PU_TAIL} purpose_e;

  // Configuration
  logic                 mode_q;
  logic [E_W-1:0]       size_q;
  logic [E_W-1:0]       eff_e, clr_e;
  logic [CNT_W-1:0]     total;
  logic [PTR_W-1:0]     tot_m1;

  // Buffer state
  logic [DEPTH-1:0]     valid_q;
  logic [THR_W+TAG_BITS-1:0] mem_q [DEPTH];
  logic [THR_W+TAG_BITS-1:0] rdata_q;
  logic [PTR_W-1:0]     thr_head_q [THREADS];
  logic [PTR_W-1:0]     thr_tail_q [THREADS];
  logic [CNT_W-1:0]     thr_cnt_q  [THREADS];
  logic [PTR_W-1:0]     sh_head_q, sh_tail_q;
  logic [CNT_W-1:0]     sh_cnt_q;

  // Current item
  logic [FUNC_W-1:0]    func_q;
  logic [THR_W-1:0]     thr_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [REL_W-1:0]     rel_q;

  // Scan unit
  logic [PTR_W-1:0]     scan_pos_q;
  logic [CNT_W-1:0]     scan_i_q;
  logic [REL_W-1:0]     scan_seen_q, scan_k_q;
  logic                 scan_back_q;
  purpose_e             purpose_q;

  // Working results
  logic [STAT_W-1:0]    stat_q;
  logic [TAG_BITS-1:0]  rtag_q, htag_q, ttag_q;
  logic                 rvalid_q, hvalid_q, tvalid_q, cdeq_q;

  // Published result
  logic [STAT_W-1:0]    o_stat_q;
  logic [TAG_BITS-1:0]  o_rtag_q, o_htag_q, o_ttag_q;
  logic                 o_rvalid_q, o_hvalid_q, o_tvalid_q, o_cenq_q, o_cdeq_q;
  logic [CNT_W-1:0]     o_cnt_q;

  logic [PTR_W-1:0]     lo, lo_end, t_head, t_tail, t_prev, priv_addr, sh_prev;
  logic [PTR_W-1:0]     pos_next, pos_prev, rd_addr, mem_waddr;
  logic [CNT_W-1:0]     t_cnt, off;
  logic                 priv_enq_ok, sh_enq_ok, mem_we, match;
  logic [TAG_BITS-1:0]  rd_tag;
  logic [THR_W-1:0]     rd_owner;

  assign eff_e  = eff_size(size_q);
  assign clr_e  = (cfg_idx_i == REG_SIZE) ? eff_size(cfg_data_i) : eff_e;
  assign total  = CNT_W'(eff_e) * CNT_W'(THREADS);
  assign tot_m1 = PTR_W'(total - CNT_W'(1));

  assign t_head = thr_head_q[thr_q];
  assign t_tail = thr_tail_q[thr_q];
  assign t_cnt  = thr_cnt_q[thr_q];
  assign lo     = PTR_W'(CNT_W'(thr_q) * CNT_W'(eff_e));
  assign lo_end = lo + PTR_W'(eff_e) - PTR_W'(1);
  assign t_prev = (t_tail == lo) ? lo_end : t_tail - PTR_W'(1);

  // Private read slot: offset from head wraps inside the partition
  always_comb begin
    off = CNT_W'(t_head - lo) + CNT_W'(rel_q);
    if (off >= CNT_W'(eff_e)) off = off - CNT_W'(eff_e);
  end
  assign priv_addr = lo + PTR_W'(off);

  assign sh_prev  = (sh_tail_q == '0) ? tot_m1 : sh_tail_q - PTR_W'(1);
  assign pos_next = (CNT_W'(scan_pos_q) + CNT_W'(1) >= total) ? '0 : scan_pos_q + PTR_W'(1);
  assign pos_prev = (scan_pos_q == '0) ? tot_m1 : scan_pos_q - PTR_W'(1);

  assign priv_enq_ok = (func_q == FN_ENQ) && (t_cnt < CNT_W'(eff_e));
  assign sh_enq_ok   = (func_q == FN_ENQ) && (sh_cnt_q < total);
  assign mem_we      = ((cmd_i.op == CMD_PRIV_OP) && priv_enq_ok) ||
                       ((cmd_i.op == CMD_SH_OP) && sh_enq_ok);
  assign mem_waddr   = mode_q ? sh_tail_q : t_tail;

  assign rd_tag   = rdata_q[TAG_BITS-1:0];
  assign rd_owner = rdata_q[THR_W+TAG_BITS-1:TAG_BITS];
  assign match    = valid_q[scan_pos_q] && (rd_owner == thr_q);

  // Select the read address for this cycle
  always_comb begin
    case (cmd_i.op)
      CMD_PRIV_OP:  rd_addr = priv_addr;
      CMD_RD_HEAD:  rd_addr = t_head;
      CMD_RD_TAIL:  rd_addr = t_prev;
      CMD_RD_SHEAD: rd_addr = sh_head_q;
      default:      rd_addr = scan_pos_q;
    endcase
  end

  // Status toward the controller
  always_comb begin
    stat_o.mode_shared  = mode_q;
    stat_o.priv_read_ok = (func_q == FN_READ) && (CNT_W'(rel_q) < t_cnt);
    stat_o.op_scan      = (((func_q == FN_REM_OLD) || (func_q == FN_REM_YOUNG)) &&
                           (t_cnt != '0)) ||
                          ((func_q == FN_READ) && (CNT_W'(rel_q) < t_cnt));
    stat_o.trim_h_more  = (sh_cnt_q != '0) && !valid_q[sh_head_q];
    stat_o.trim_t_more  = (sh_cnt_q != '0) && !valid_q[sh_prev];
    stat_o.scan_end     = (scan_i_q == sh_cnt_q);
    stat_o.scan_hit     = match && (scan_back_q || (scan_seen_q == scan_k_q));
    stat_o.tcnt_nz      = (t_cnt != '0);
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= {thr_q, tag_q};
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Control and result state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      size_q      <= E_W'(MAX_PER_THREAD);
      valid_q     <= '0;
      for (int t = 0; t < THREADS; t++) begin
        thr_head_q[t] <= PTR_W'(t * MAX_PER_THREAD);
        thr_tail_q[t] <= PTR_W'(t * MAX_PER_THREAD);
        thr_cnt_q[t]  <= '0;
      end
      sh_head_q   <= '0;
      sh_tail_q   <= '0;
      sh_cnt_q    <= '0;
      func_q      <= FN_STATUS;
      thr_q       <= '0;
      tag_q       <= '0;
      rel_q       <= '0;
      scan_pos_q  <= '0;
      scan_i_q    <= '0;
      scan_seen_q <= '0;
      scan_k_q    <= '0;
      scan_back_q <= 1'b0;
      purpose_q   <= PU_REMOVE;
      stat_q      <= RS_OK;
      rtag_q      <= '0;
      htag_q      <= '0;
      ttag_q      <= '0;
      rvalid_q    <= 1'b0;
      hvalid_q    <= 1'b0;
      tvalid_q    <= 1'b0;
      cdeq_q      <= 1'b0;
      o_stat_q    <= RS_OK;
      o_rtag_q    <= '0;
      o_htag_q    <= '0;
      o_ttag_q    <= '0;
      o_rvalid_q  <= 1'b0;
      o_hvalid_q  <= 1'b0;
      o_tvalid_q  <= 1'b0;
      o_cenq_q    <= 1'b0;
      o_cdeq_q    <= 1'b0;
      o_cnt_q     <= '0;
    end else begin
      // Register write: update setting and empty the buffer
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MODE) begin
          mode_q <= cfg_data_i[0];
        end else begin
          size_q <= cfg_data_i[E_W-1:0];
        end
        valid_q <= '0;
        for (int t = 0; t < THREADS; t++) begin
          thr_head_q[t] <= PTR_W'(CNT_W'(t) * CNT_W'(clr_e));
          thr_tail_q[t] <= PTR_W'(CNT_W'(t) * CNT_W'(clr_e));
          thr_cnt_q[t]  <= '0;
        end
        sh_head_q <= '0;
        sh_tail_q <= '0;
        sh_cnt_q  <= '0;
      end

      case (cmd_i.op)
        // Latch the item and clear the working result
        CMD_LOAD: begin
          func_q   <= func_i;
          thr_q    <= thread_id_i;
          tag_q    <= entry_tag_i[TAG_BITS-1:0];
          rel_q    <= rel_index_i;
          stat_q   <= RS_OK;
          rtag_q   <= '0;
          htag_q   <= '0;
          ttag_q   <= '0;
          rvalid_q <= 1'b0;
          hvalid_q <= 1'b0;
          tvalid_q <= 1'b0;
          cdeq_q   <= 1'b0;
        end
        // Private partition update
        CMD_PRIV_OP: begin
          if (func_q == FN_ENQ) begin
            if (priv_enq_ok) begin
              valid_q[t_tail]   <= 1'b1;
              thr_tail_q[thr_q] <= (t_tail == lo_end) ? lo : t_tail + PTR_W'(1);
              thr_cnt_q[thr_q]  <= t_cnt + CNT_W'(1);
            end else begin
              stat_q <= RS_FULL;
            end
          end else if (func_q == FN_REM_OLD) begin
            if (t_cnt != '0) begin
              valid_q[t_head]   <= 1'b0;
              thr_head_q[thr_q] <= (t_head == lo_end) ? lo : t_head + PTR_W'(1);
              thr_cnt_q[thr_q]  <= t_cnt - CNT_W'(1);
            end else begin
              stat_q <= RS_EMPTY;
            end
          end else if (func_q == FN_REM_YOUNG) begin
            if (t_cnt != '0) begin
              valid_q[t_prev]   <= 1'b0;
              thr_tail_q[thr_q] <= t_prev;
              thr_cnt_q[thr_q]  <= t_cnt - CNT_W'(1);
            end else begin
              stat_q <= RS_EMPTY;
            end
          end else if (func_q == FN_READ) begin
            if (CNT_W'(rel_q) >= t_cnt) stat_q <= RS_RANGE;
          end
        end
        CMD_CAP_R: begin
          rtag_q   <= rd_tag;
          rvalid_q <= 1'b1;
        end
        CMD_CAP_H: begin
          if (t_cnt != '0) begin
            htag_q   <= rd_tag;
            hvalid_q <= 1'b1;
          end
        end
        CMD_CAP_T: begin
          if (t_cnt != '0) begin
            ttag_q   <= rd_tag;
            tvalid_q <= 1'b1;
          end
        end
        // Drop one hole at either end of the shared span
        CMD_TRIM_H: begin
          if (stat_o.trim_h_more) begin
            sh_head_q <= (CNT_W'(sh_head_q) + CNT_W'(1) >= total) ? '0 :
                         sh_head_q + PTR_W'(1);
            sh_cnt_q  <= sh_cnt_q - CNT_W'(1);
          end
        end
        CMD_TRIM_T: begin
          if (stat_o.trim_t_more) begin
            sh_tail_q <= sh_prev;
            sh_cnt_q  <= sh_cnt_q - CNT_W'(1);
          end
        end
        // Shared enqueue, failure codes, and scan setup for the operation
        CMD_SH_OP: begin
          if (func_q == FN_ENQ) begin
            if (sh_enq_ok) begin
              valid_q[sh_tail_q] <= 1'b1;
              sh_tail_q <= (CNT_W'(sh_tail_q) + CNT_W'(1) >= total) ? '0 :
                           sh_tail_q + PTR_W'(1);
              sh_cnt_q  <= sh_cnt_q + CNT_W'(1);
              thr_cnt_q[thr_q] <= t_cnt + CNT_W'(1);
            end else begin
              stat_q <= RS_FULL;
            end
          end else if ((func_q == FN_REM_OLD) || (func_q == FN_REM_YOUNG)) begin
            if (t_cnt == '0) stat_q <= RS_EMPTY;
          end else if (func_q == FN_READ) begin
            if (CNT_W'(rel_q) >= t_cnt) stat_q <= RS_RANGE;
          end
          scan_back_q <= (func_q == FN_REM_YOUNG);
          scan_pos_q  <= (func_q == FN_REM_YOUNG) ? sh_prev : sh_head_q;
          scan_k_q    <= (func_q == FN_READ) ? rel_q : '0;
          purpose_q   <= (func_q == FN_READ) ? PU_READ : PU_REMOVE;
          scan_i_q    <= '0;
          scan_seen_q <= '0;
        end
        CMD_SCAN_HEAD: begin
          scan_back_q <= 1'b0;
          scan_pos_q  <= sh_head_q;
          scan_k_q    <= '0;
          purpose_q   <= PU_HEAD;
          scan_i_q    <= '0;
          scan_seen_q <= '0;
        end
        CMD_SCAN_TAIL: begin
          scan_back_q <= 1'b1;
          scan_pos_q  <= sh_prev;
          scan_k_q    <= '0;
          purpose_q   <= PU_TAIL;
          scan_i_q    <= '0;
          scan_seen_q <= '0;
        end
        // Span exhausted without a hit
        CMD_SCAN_ISSUE: begin
          if (stat_o.scan_end) begin
            if (purpose_q == PU_REMOVE) stat_q <= RS_EMPTY;
            if (purpose_q == PU_READ)   stat_q <= RS_RANGE;
          end
        end
        // Examine one slot of the span
        CMD_SCAN_CHECK: begin
          if (stat_o.scan_hit) begin
            case (purpose_q)
              PU_REMOVE: begin
                valid_q[scan_pos_q] <= 1'b0;
                thr_cnt_q[thr_q]    <= t_cnt - CNT_W'(1);
              end
              PU_READ: begin
                rtag_q   <= rd_tag;
                rvalid_q <= 1'b1;
              end
              PU_HEAD: begin
                htag_q   <= rd_tag;
                hvalid_q <= 1'b1;
              end
              default: begin
                ttag_q   <= rd_tag;
                tvalid_q <= 1'b1;
              end
            endcase
          end else begin
            if (match) scan_seen_q <= scan_seen_q + REL_W'(1);
            scan_pos_q <= scan_back_q ? pos_prev : pos_next;
            scan_i_q   <= scan_i_q + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase

      // Owner of the buffer's oldest slot decides shared dequeue
      if (cmd_i.cap_deq) begin
        cdeq_q <= (sh_cnt_q != '0) && valid_q[sh_head_q] && (rd_owner == thr_q);
      end

      // Hand the finished result to the output register
      if (cmd_i.publish) begin
        o_stat_q   <= stat_q;
        o_rtag_q   <= rtag_q;
        o_rvalid_q <= rvalid_q;
        o_htag_q   <= htag_q;
        o_hvalid_q <= hvalid_q;
        o_ttag_q   <= ttag_q;
        o_tvalid_q <= tvalid_q;
        o_cnt_q    <= t_cnt;
        o_cenq_q   <= mode_q ? (sh_cnt_q < total) : (t_cnt < CNT_W'(eff_e));
        o_cdeq_q   <= mode_q ? cdeq_q : (t_cnt != '0);
      end
    end
  end

  assign status_o       = o_stat_q;
  assign read_tag_o     = PORT_TAG_W'(o_rtag_q);
  assign read_valid_o   = o_rvalid_q;
  assign head_tag_o     = PORT_TAG_W'(o_htag_q);
  assign head_valid_o   = o_hvalid_q;
  assign tail_tag_o     = PORT_TAG_W'(o_ttag_q);
  assign tail_valid_o   = o_tvalid_q;
  assign thread_count_o = o_cnt_q;
  assign can_enqueue_o  = o_cenq_q;
  assign can_dequeue_o  = o_cdeq_q;

endmodule

// ===== sv/mtrob_ctrl.sv =====
module mtrob_ctrl import mtrob_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_P_OP, ST_P_CAPR, ST_P_RDH, ST_P_CAPH, ST_P_RDT, ST_P_CAPT,
    ST_TRIM_H, ST_TRIM_T, ST_S_OP, ST_SCAN_ISSUE, ST_SCAN_CHECK,
    ST_HEAD_INIT, ST_TAIL_INIT, ST_S_RDH, ST_S_CAPD, ST_FINISH
  } state_e;

  typedef enum logic [1:0] {PH_OP, PH_HEAD, PH_TAIL} phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   second_q, second_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  state_e after_scan;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (phase_q)
      PH_OP:   after_scan = ST_TRIM_H;
      PH_HEAD: after_scan = ST_TAIL_INIT;
      default: after_scan = ST_S_RDH;
    endcase
  end

  // Sequence one item through the datapath
  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    second_d      = second_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.op      = CMD_NONE;
    cmd_o.cap_deq = 1'b0;
    cmd_o.publish = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          second_d = 1'b0;
          state_d  = stat_i.mode_shared ? ST_TRIM_H : ST_P_OP;
        end
      end
      ST_P_OP: begin
        cmd_o.op = CMD_PRIV_OP;
        state_d  = stat_i.priv_read_ok ? ST_P_CAPR : ST_P_RDH;
      end
      ST_P_CAPR: begin
        cmd_o.op = CMD_CAP_R;
        state_d  = ST_P_RDH;
      end
      ST_P_RDH: begin
        cmd_o.op = CMD_RD_HEAD;
        state_d  = ST_P_CAPH;
      end
      ST_P_CAPH: begin
        cmd_o.op = CMD_CAP_H;
        state_d  = ST_P_RDT;
      end
      ST_P_RDT: begin
        cmd_o.op = CMD_RD_TAIL;
        state_d  = ST_P_CAPT;
      end
      ST_P_CAPT: begin
        cmd_o.op = CMD_CAP_T;
        state_d  = ST_FINISH;
      end
      ST_TRIM_H: begin
        cmd_o.op = CMD_TRIM_H;
        if (!stat_i.trim_h_more) state_d = ST_TRIM_T;
      end
      ST_TRIM_T: begin
        cmd_o.op = CMD_TRIM_T;
        if (!stat_i.trim_t_more) state_d = second_q ? ST_HEAD_INIT : ST_S_OP;
      end
      ST_S_OP: begin
        cmd_o.op = CMD_SH_OP;
        phase_d  = PH_OP;
        second_d = 1'b1;
        state_d  = stat_i.op_scan ? ST_SCAN_ISSUE : ST_TRIM_H;
      end
      ST_SCAN_ISSUE: begin
        cmd_o.op = CMD_SCAN_ISSUE;
        state_d  = stat_i.scan_end ? after_scan : ST_SCAN_CHECK;
      end
      ST_SCAN_CHECK: begin
        cmd_o.op = CMD_SCAN_CHECK;
        state_d  = stat_i.scan_hit ? after_scan : ST_SCAN_ISSUE;
      end
      ST_HEAD_INIT: begin
        if (stat_i.tcnt_nz) begin
          cmd_o.op = CMD_SCAN_HEAD;
          phase_d  = PH_HEAD;
          state_d  = ST_SCAN_ISSUE;
        end else begin
          state_d  = ST_S_RDH;
        end
      end
      ST_TAIL_INIT: begin
        cmd_o.op = CMD_SCAN_TAIL;
        phase_d  = PH_TAIL;
        state_d  = ST_SCAN_ISSUE;
      end
      ST_S_RDH: begin
        cmd_o.op = CMD_RD_SHEAD;
        state_d  = ST_S_CAPD;
      end
      ST_S_CAPD: begin
        cmd_o.cap_deq = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_OP;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/multithread_reorder_buffer.sv =====
// Reorder buffer for up to four threads, one operation per transfer.
// Input channel (in_valid_i/in_ready_o) carries func, thread, tag and index;
// output channel (out_valid_o/out_ready_i) returns one result per item with
// status, read tag, the thread's head and tail tags, its count and flags.
// The cfg port writes mode (index 0) or entries per thread (index 1);
// either write empties the buffer. Write it only while idle.
// Items are handled one at a time. Private mode: the update (which also
// reads the slot for a read), then the read tag for a read that hits, the
// head tag and the tail tag, each fetched in turn from the slot memory.
// Shared mode: holes trimmed at both ends of the occupied span, the operation
// and a scan of the span when it needs one, a second trim, scans for the
// thread's head and tail when it holds entries, then a read of the oldest slot
// (up to three scans of up to 256 slots; the slot memory gives one read a cycle).
// The result sits in an output register, so the next item is taken as soon
// as the current one is published; a stalled receiver holds the result and
// blocks only the publish of the following item.
// Reset empties every slot, puts each thread's pointers at its partition
// start, selects private mode and 64 entries per thread.
module multithread_reorder_buffer import mtrob_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [THR_W-1:0]      thread_id_i,
  input  logic [PORT_TAG_W-1:0] entry_tag_i,
  input  logic [REL_W-1:0]      rel_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STAT_W-1:0]     status_o,
  output logic [PORT_TAG_W-1:0] read_tag_o,
  output logic                  read_valid_o,
  output logic [PORT_TAG_W-1:0] head_tag_o,
  output logic                  head_valid_o,
  output logic [PORT_TAG_W-1:0] tail_tag_o,
  output logic                  tail_valid_o,
  output logic [CNT_W-1:0]      thread_count_o,
  output logic                  can_enqueue_o,
  output logic                  can_dequeue_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mtrob_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mtrob_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .thread_id_i    (thread_id_i),
    .entry_tag_i    (entry_tag_i),
    .rel_index_i    (rel_index_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .status_o       (status_o),
    .read_tag_o     (read_tag_o),
    .read_valid_o   (read_valid_o),
    .head_tag_o     (head_tag_o),
    .head_valid_o   (head_valid_o),
    .tail_tag_o     (tail_tag_o),
    .tail_valid_o   (tail_valid_o),
    .thread_count_o (thread_count_o),
    .can_enqueue_o  (can_enqueue_o),
    .can_dequeue_o  (can_dequeue_o)
  );

endmodule

// ===== sv/mtrob_checker.sv =====
module mtrob_checker import mtrob_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [STAT_W-1:0]     status_o,
  input logic [PORT_TAG_W-1:0] read_tag_o,
  input logic                  read_valid_o,
  input logic                  head_valid_o,
  input logic                  tail_valid_o,
  input logic [CNT_W-1:0]      thread_count_o,
  input logic                  can_enqueue_o
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(thread_count_o))
    else $error("result changed while stalled");

  // A read tag is given only with ok status, and is zero otherwise
  a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_valid_o ? (status_o == RS_OK) : (read_tag_o == '0)))
    else $error("read tag inconsistent with status");

  // Head and tail are present exactly when the thread holds entries
  a_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_valid_o == tail_valid_o) &&
    (head_valid_o == (thread_count_o != '0)))
    else $error("head/tail validity disagrees with count");

  // A refused enqueue leaves no room reported
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == RS_FULL) |-> !can_enqueue_o)
    else $error("full status with room reported");

endmodule

bind multithread_reorder_buffer mtrob_checker u_mtrob_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .read_tag_o     (read_tag_o),
  .read_valid_o   (read_valid_o),
  .head_valid_o   (head_valid_o),
  .tail_valid_o   (tail_valid_o),
  .thread_count_o (thread_count_o),
  .can_enqueue_o  (can_enqueue_o)
);
